// ----- rtl/core/yrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types and constants for the YCbCr to RGB pixel pair converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

    localparam int PIX_W    = 8;
    localparam int DIFF_W   = PIX_W + 1;
    localparam int COEF_W   = 18;
    localparam int FRAC_W   = 16;
    localparam int TERM_W   = 26;
    localparam int PROD_W   = DIFF_W + COEF_W;
    localparam int CLAMP_W  = TERM_W - FRAC_W;

    localparam logic signed [COEF_W-1:0] COEF_CR_TO_R = 18'sd91881;
    localparam logic signed [COEF_W-1:0] COEF_CB_TO_G = 18'sd22554;
    localparam logic signed [COEF_W-1:0] COEF_CR_TO_G = 18'sd46802;
    localparam logic signed [COEF_W-1:0] COEF_CB_TO_B = 18'sd116130;

    localparam logic [PIX_W-1:0] CHANNEL_MAX = 8'd255;
    localparam logic [PIX_W-1:0] CHANNEL_MIN = 8'd0;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic signed [TERM_W-1:0] cr_to_r;
        logic signed [TERM_W-1:0] cb_to_g;
        logic signed [TERM_W-1:0] cr_to_g;
        logic signed [TERM_W-1:0] cb_to_b;
    } chroma_terms_t;

    typedef struct packed {
        pixel_t red;
        pixel_t green;
        pixel_t blue;
    } rgb_t;

endpackage

// ----- rtl/core/yrgb_chroma.sv -----
// ----------------------------------------------------------------------------
// yrgb_chroma
// Chroma stage: forms the four scaled chroma terms shared by both lanes.
// ----------------------------------------------------------------------------
module yrgb_chroma
(
    input  logic                   clk,
    input  logic                   load,
    input  yrgb_pkg::pixel_t       chroma_blue,
    input  yrgb_pkg::pixel_t       chroma_red,
    output yrgb_pkg::chroma_terms_t terms
);
    import yrgb_pkg::*;

    logic signed [DIFF_W-1:0] db;
    logic signed [DIFF_W-1:0] dr;
    logic signed [PROD_W-1:0] cr_r_prod;
    logic signed [PROD_W-1:0] cb_g_prod;
    logic signed [PROD_W-1:0] cr_g_prod;
    logic signed [PROD_W-1:0] cb_b_prod;
    chroma_terms_t            terms_reg;
    chroma_terms_t            terms_next;

    // remove the chroma offset
    assign db = signed'({~chroma_blue[PIX_W-1], ~chroma_blue[PIX_W-1],
                         chroma_blue[PIX_W-2:0]});
    assign dr = signed'({~chroma_red[PIX_W-1], ~chroma_red[PIX_W-1],
                         chroma_red[PIX_W-2:0]});

    assign cr_r_prod = PROD_W'(dr) * PROD_W'(COEF_CR_TO_R);
    assign cb_g_prod = PROD_W'(db) * PROD_W'(COEF_CB_TO_G);
    assign cr_g_prod = PROD_W'(dr) * PROD_W'(COEF_CR_TO_G);
    assign cb_b_prod = PROD_W'(db) * PROD_W'(COEF_CB_TO_B);

    always_comb
    begin
        terms_next         = terms_reg;
        terms_next.cr_to_r = cr_r_prod[TERM_W-1:0];
        terms_next.cb_to_g = cb_g_prod[TERM_W-1:0];
        terms_next.cr_to_g = cr_g_prod[TERM_W-1:0];
        terms_next.cb_to_b = cb_b_prod[TERM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// ----- rtl/core/yrgb_lane.sv -----
// ----------------------------------------------------------------------------
// yrgb_lane
// Pixel lane: adds luma to the chroma terms, floors and clamps each channel.
// ----------------------------------------------------------------------------
module yrgb_lane
(
    input  yrgb_pkg::pixel_t        luma,
    input  yrgb_pkg::chroma_terms_t terms,
    output yrgb_pkg::rgb_t          rgb
);
    import yrgb_pkg::*;

    logic signed [TERM_W-1:0] base;
    logic signed [TERM_W-1:0] red_sum;
    logic signed [TERM_W-1:0] green_sum;
    logic signed [TERM_W-1:0] blue_sum;

    function automatic pixel_t clamp_channel(input logic signed [TERM_W-1:0] sum);
        logic [CLAMP_W-1:0] q;
        q = sum[TERM_W-1:FRAC_W];
        if (q[CLAMP_W-1])
            return CHANNEL_MIN;
        else if (q[CLAMP_W-2:PIX_W] != '0)
            return CHANNEL_MAX;
        else
            return q[PIX_W-1:0];
    endfunction

    assign base      = signed'({{(TERM_W-FRAC_W-PIX_W){1'b0}}, luma, {FRAC_W{1'b0}}});
    assign red_sum   = base + terms.cr_to_r;
    assign green_sum = base - terms.cb_to_g - terms.cr_to_g;
    assign blue_sum  = base + terms.cb_to_b;

    assign rgb.red   = clamp_channel(red_sum);
    assign rgb.green = clamp_channel(green_sum);
    assign rgb.blue  = clamp_channel(blue_sum);

endmodule

// ----- rtl/core/yuv_to_rgb_pixel_pair.sv -----
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_pair
// Full-range BT.601 YCbCr 4:2:2 pixel pair to two RGB24 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Present luma_first, luma_second, chroma_blue and chroma_red with start
//   high; the item is taken at the clock edge where start is high and busy
//   is low. busy is always low, so one item may be offered every cycle.
//   The chroma stage registers the four scaled chroma terms, then two pixel
//   lanes add luma, floor and clamp, and the merge register presents both
//   pixels with done high for one cycle. Throughput is one item per clock,
//   set by the two-stage pipeline with one multiplier per chroma term.
//   The receiver cannot stall: each result stays on the ports only until
//   the next result is merged. Reset clears the stage valid flag and done;
//   the payload registers are not reset.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_pair
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  yrgb_pkg::pixel_t luma_first,
    input  yrgb_pkg::pixel_t luma_second,
    input  yrgb_pkg::pixel_t chroma_blue,
    input  yrgb_pkg::pixel_t chroma_red,
    output logic             done,
    output yrgb_pkg::pixel_t red_first,
    output yrgb_pkg::pixel_t green_first,
    output yrgb_pkg::pixel_t blue_first,
    output yrgb_pkg::pixel_t red_second,
    output yrgb_pkg::pixel_t green_second,
    output yrgb_pkg::pixel_t blue_second
);
    import yrgb_pkg::*;

    logic          accept;
    logic          stage_valid_reg;
    logic          stage_valid_next;
    logic          done_reg;
    logic          done_next;
    pixel_t        luma_first_reg;
    pixel_t        luma_second_reg;
    chroma_terms_t terms;
    rgb_t          lane_first;
    rgb_t          lane_second;
    rgb_t          pix_first_reg;
    rgb_t          pix_second_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    yrgb_chroma u_chroma
    (
        .clk         (clk),
        .load        (accept),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .terms       (terms)
    );

    yrgb_lane u_lane_first
    (
        .luma  (luma_first_reg),
        .terms (terms),
        .rgb   (lane_first)
    );

    yrgb_lane u_lane_second
    (
        .luma  (luma_second_reg),
        .terms (terms),
        .rgb   (lane_second)
    );

    assign stage_valid_next = accept;
    assign done_next        = stage_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            done_reg        <= done_next;
        end
    end

    // hold luma alongside the chroma terms
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            luma_first_reg  <= luma_first;
            luma_second_reg <= luma_second;
        end
    end

    // merge both lanes into the result register
    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            pix_first_reg  <= lane_first;
            pix_second_reg <= lane_second;
        end
    end

    assign done         = done_reg;
    assign red_first    = pix_first_reg.red;
    assign green_first  = pix_first_reg.green;
    assign blue_first   = pix_first_reg.blue;
    assign red_second   = pix_second_reg.red;
    assign green_second = pix_second_reg.green;
    assign blue_second  = pix_second_reg.blue;

endmodule
